// ===== rtl/mcd_pkg.sv =====
`default_nettype none
package mcd_pkg;

  localparam int CHANNELS            = 3;
  localparam int SENSORS_PER_CHANNEL = 4;
  localparam int CALIB_SAMPLES       = 10;

  localparam int SLOTS  = CHANNELS * SENSORS_PER_CHANNEL;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int CHAN_W     = 2;
  localparam int SENSOR_W   = 2;
  localparam int FIELD_W    = 16;
  localparam int CORR_W     = 17;
  localparam int SUM_W      = 20;
  localparam int CNT_W      = 4;
  localparam int THR_W      = 16;
  localparam int MASK_W     = 12;
  localparam int MASK_IDX_W = 4;
  localparam int STOP_W     = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]  RESET_THRESHOLD = 16'd500;
  localparam logic [MASK_W-1:0] RESET_PRESENT   = 12'hFFF;

  // Division by the sample count as a multiply by a rounded-up reciprocal.
  localparam int DIV_SHIFT = 24;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam longint DIV_RECIP =
    ((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam int PROD_W    = SUM_W + RECIP_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_PRESENT   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                     cal;
    logic [CHAN_W-1:0]        chan;
    logic signed [FIELD_W-1:0] fx;
    logic signed [FIELD_W-1:0] fy;
    logic signed [FIELD_W-1:0] fz;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  sz;
    logic                     last;
  } item_t;

endpackage
`default_nettype wire

// ===== rtl/mcd_front.sv =====
`default_nettype none
module mcd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          push,
  input  wire logic [mcd_pkg::CHAN_W-1:0]     channel,
  input  wire logic [mcd_pkg::SENSOR_W-1:0]   sensor,
  input  wire logic                          read_ok,
  input  wire logic signed [mcd_pkg::FIELD_W-1:0] field_x,
  input  wire logic signed [mcd_pkg::FIELD_W-1:0] field_y,
  input  wire logic signed [mcd_pkg::FIELD_W-1:0] field_z,
  input  wire logic                          last_of_sweep,
  output mcd_pkg::item_t                     item,
  output logic [mcd_pkg::THR_W-1:0]          z_threshold
);
  import mcd_pkg::*;

  logic [THR_W-1:0]        thr_r;
  logic [MASK_W-1:0]       present_r;
  logic signed [SUM_W-1:0] sum_x_r [SLOTS];
  logic signed [SUM_W-1:0] sum_y_r [SLOTS];
  logic signed [SUM_W-1:0] sum_z_r [SLOTS];
  logic [CNT_W-1:0]        cnt_r   [SLOTS];

  logic [31:0]       slot_full;
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  logic              usable;
  logic              calibrating;

  always_comb begin
    slot_full = 32'(channel) * 32'(SENSORS_PER_CHANNEL) + 32'(sensor);
    slot      = slot_full[SLOT_W-1:0];
    slot_ok   = (32'(channel) < 32'(CHANNELS)) && (32'(sensor) < 32'(SENSORS_PER_CHANNEL)) &&
                (slot_full < 32'(SLOTS)) && (slot_full < 32'(MASK_W));
    usable    = slot_ok && present_r[slot_full[MASK_IDX_W-1:0]] && read_ok;
    calibrating = cnt_r[slot] < CNT_W'(CALIB_SAMPLES);

    item.cal  = usable && !calibrating;
    item.chan = channel;
    item.fx   = field_x;
    item.fy   = field_y;
    item.fz   = field_z;
    item.sx   = sum_x_r[slot];
    item.sy   = sum_y_r[slot];
    item.sz   = sum_z_r[slot];
    item.last = last_of_sweep;
  end

  assign z_threshold = thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= RESET_THRESHOLD;
      present_r <= RESET_PRESENT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        CFG_PRESENT:   present_r <= cfg_wdata[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        sum_x_r[i] <= '0;
        sum_y_r[i] <= '0;
        sum_z_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else if (push && usable && calibrating) begin
      sum_x_r[slot] <= sum_x_r[slot] + SUM_W'(field_x);
      sum_y_r[slot] <= sum_y_r[slot] + SUM_W'(field_y);
      sum_z_r[slot] <= sum_z_r[slot] + SUM_W'(field_z);
      cnt_r[slot]   <= cnt_r[slot] + CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcd_queue.sv =====
`default_nettype none
module mcd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire mcd_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output mcd_pkg::item_t      head_item
);
  import mcd_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (32'(wr_r) == QUEUE_DEPTH - 1) ? '0 : wr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_r <= (32'(rd_r) == QUEUE_DEPTH - 1) ? '0 : rd_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mcd_back.sv =====
`default_nettype none
module mcd_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire mcd_pkg::item_t              q_item,
  output logic                             pop,
  input  wire logic [mcd_pkg::THR_W-1:0]   z_threshold,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output logic                             res_out_valid,
  output logic signed [mcd_pkg::CORR_W-1:0] res_corr_x,
  output logic signed [mcd_pkg::CORR_W-1:0] res_corr_y,
  output logic signed [mcd_pkg::CORR_W-1:0] res_corr_z,
  output logic                             res_over,
  output logic [mcd_pkg::STOP_W-1:0]       res_stop_mask,
  output logic                             res_contact,
  output logic                             res_sweep_done
);
  import mcd_pkg::*;

  logic                      s1_vld_r;
  logic                      s1_cal_r;
  logic [CHAN_W-1:0]         s1_chan_r;
  logic signed [FIELD_W-1:0] s1_fx_r, s1_fy_r, s1_fz_r;
  logic                      s1_last_r;
  logic [PROD_W-1:0]         s1_px_r, s1_py_r, s1_pz_r;
  logic                      s1_nx_r, s1_ny_r, s1_nz_r;

  logic                      out_vld_r;
  logic                      o_valid_r;
  logic signed [CORR_W-1:0]  o_cx_r, o_cy_r, o_cz_r;
  logic                      o_over_r;
  logic [STOP_W-1:0]         o_mask_r;
  logic                      o_contact_r;
  logic                      o_done_r;
  logic [STOP_W-1:0]         sweep_r;

  logic out_load;
  logic s1_adv;

  logic [SUM_W-1:0]          ax, ay, az;
  logic signed [CORR_W-1:0]  cx, cy, cz;
  logic [CORR_W-1:0]         mag;
  logic                      over;
  logic [STOP_W-1:0]         stop_bits;
  logic [STOP_W-1:0]         stop_nxt;

  function automatic logic signed [CORR_W-1:0] correct(
    input logic signed [FIELD_W-1:0] f,
    input logic [PROD_W-1:0]         p,
    input logic                      neg
  );
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] d;
    q = p[DIV_SHIFT +: SUM_W];
    if (neg) begin
      q = -q;
    end
    d = SUM_W'(f) - q;
    return d[CORR_W-1:0];
  endfunction

  assign out_load = !out_vld_r || res_ready;
  assign s1_adv   = !s1_vld_r || out_load;
  assign pop      = q_valid && s1_adv;

  always_comb begin
    ax = q_item.sx[SUM_W-1] ? SUM_W'(-q_item.sx) : SUM_W'(q_item.sx);
    ay = q_item.sy[SUM_W-1] ? SUM_W'(-q_item.sy) : SUM_W'(q_item.sy);
    az = q_item.sz[SUM_W-1] ? SUM_W'(-q_item.sz) : SUM_W'(q_item.sz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_cal_r  <= q_item.cal;
      s1_chan_r <= q_item.chan;
      s1_fx_r   <= q_item.fx;
      s1_fy_r   <= q_item.fy;
      s1_fz_r   <= q_item.fz;
      s1_last_r <= q_item.last;
      s1_px_r   <= PROD_W'(ax) * PROD_W'(DIV_RECIP);
      s1_py_r   <= PROD_W'(ay) * PROD_W'(DIV_RECIP);
      s1_pz_r   <= PROD_W'(az) * PROD_W'(DIV_RECIP);
      s1_nx_r   <= q_item.sx[SUM_W-1];
      s1_ny_r   <= q_item.sy[SUM_W-1];
      s1_nz_r   <= q_item.sz[SUM_W-1];
    end
  end

  always_comb begin
    cx   = s1_cal_r ? correct(s1_fx_r, s1_px_r, s1_nx_r) : '0;
    cy   = s1_cal_r ? correct(s1_fy_r, s1_py_r, s1_ny_r) : '0;
    cz   = s1_cal_r ? correct(s1_fz_r, s1_pz_r, s1_nz_r) : '0;
    mag  = cz[CORR_W-1] ? CORR_W'(-cz) : CORR_W'(cz);
    over = s1_cal_r && (mag > CORR_W'(z_threshold));
    for (int i = 0; i < STOP_W; i++) begin
      stop_bits[i] = over && (32'(s1_chan_r) == i);
    end
    stop_nxt = sweep_r | stop_bits;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      sweep_r   <= '0;
    end else if (out_load) begin
      out_vld_r <= s1_vld_r;
      if (s1_vld_r) begin
        sweep_r <= s1_last_r ? '0 : stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_vld_r) begin
      o_valid_r   <= s1_cal_r;
      o_cx_r      <= cx;
      o_cy_r      <= cy;
      o_cz_r      <= cz;
      o_over_r    <= over;
      o_mask_r    <= s1_last_r ? stop_nxt : '0;
      o_contact_r <= s1_last_r && (stop_nxt != '0);
      o_done_r    <= s1_last_r;
    end
  end

  assign res_valid      = out_vld_r;
  assign res_out_valid  = o_valid_r;
  assign res_corr_x     = o_cx_r;
  assign res_corr_y     = o_cy_r;
  assign res_corr_z     = o_cz_r;
  assign res_over       = o_over_r;
  assign res_stop_mask  = o_mask_r;
  assign res_contact    = o_contact_r;
  assign res_sweep_done = o_done_r;

endmodule
`default_nettype wire

// ===== rtl/magnetic_contact_detector.sv =====
// Channel   Direction  Handshake           Carries
// in_       input      in_valid/in_ready   one tagged three-axis reading
// out_      output     out_valid/out_ready one result per reading
// cfg_      input      cfg_we              threshold and fitted-sensor mask
//
// One reading can be accepted on every cycle while in_ready is high. Each reading passes
// through the queue, the calibration sums having been updated at acceptance, and then
// through the reciprocal multiply stage before the correction is registered at the
// output. A four-entry queue separates calibration from the correction pipeline; while
// a result is held, five requests can wait before in_ready falls. Reset is synchronous
// and clears the baselines, counts and sweep mask.
`default_nettype none
module magnetic_contact_detector (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mcd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [mcd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mcd_pkg::CHAN_W-1:0]     in_channel,
  input  wire logic [mcd_pkg::SENSOR_W-1:0]   in_sensor,
  input  wire logic                          in_read_ok,
  input  wire logic signed [mcd_pkg::FIELD_W-1:0] in_field_x,
  input  wire logic signed [mcd_pkg::FIELD_W-1:0] in_field_y,
  input  wire logic signed [mcd_pkg::FIELD_W-1:0] in_field_z,
  input  wire logic                          in_last_of_sweep,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_out_valid,
  output logic signed [mcd_pkg::CORR_W-1:0]  out_corr_x,
  output logic signed [mcd_pkg::CORR_W-1:0]  out_corr_y,
  output logic signed [mcd_pkg::CORR_W-1:0]  out_corr_z,
  output logic                               out_over_threshold,
  output logic [mcd_pkg::STOP_W-1:0]         out_stop_mask,
  output logic                               out_contact,
  output logic                               out_sweep_done
);
  import mcd_pkg::*;

  item_t            front_item;
  item_t            head_item;
  logic             push;
  logic             full;
  logic             not_empty;
  logic             pop;
  logic [THR_W-1:0] z_threshold;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  mcd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .channel       (in_channel),
    .sensor        (in_sensor),
    .read_ok       (in_read_ok),
    .field_x       (in_field_x),
    .field_y       (in_field_y),
    .field_z       (in_field_z),
    .last_of_sweep (in_last_of_sweep),
    .item          (front_item),
    .z_threshold   (z_threshold)
  );

  mcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  mcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (not_empty),
    .q_item         (head_item),
    .pop            (pop),
    .z_threshold    (z_threshold),
    .res_valid      (out_valid),
    .res_ready      (out_ready),
    .res_out_valid  (out_out_valid),
    .res_corr_x     (out_corr_x),
    .res_corr_y     (out_corr_y),
    .res_corr_z     (out_corr_z),
    .res_over       (out_over_threshold),
    .res_stop_mask  (out_stop_mask),
    .res_contact    (out_contact),
    .res_sweep_done (out_sweep_done)
  );

endmodule
`default_nettype wire
